// ----- rtl/core/nrrp_pkg.sv -----
`default_nettype none

package nrrp_pkg;

   localparam int SLOTS   = 3;
   localparam int SLOT_W  = 2;
   localparam int COUNT_W = 8;
   localparam int INDEX_W = 8;
   localparam int RNG_W   = 32;
   localparam int DIV_W   = RNG_W;
   localparam int STEP_W  = $clog2(DIV_W);

   localparam logic [RNG_W-1:0]   DEFAULT_SEED = 32'h2545_F491;
   localparam logic [INDEX_W-1:0] NO_PICK      = 8'hFF;

   localparam int SHIFT_A = 13;
   localparam int SHIFT_B = 17;
   localparam int SHIFT_C = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV1,
      ST_DIV2,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [COUNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [RNG_W-1:0] xorshift(input logic [RNG_W-1:0] x);
      logic [RNG_W-1:0] t;
      t = x;
      t = t ^ (t << SHIFT_A);
      t = t ^ (t >> SHIFT_B);
      t = t ^ (t << SHIFT_C);
      return t;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nrrp_ifs.sv -----
`default_nettype none

interface nrrp_req_if;
   import nrrp_pkg::*;
   logic               valid;
   logic               ready;
   logic [SLOT_W-1:0]  slot;
   logic [COUNT_W-1:0] count;
   modport source (output valid, output slot, output count, input ready);
   modport sink (input valid, input slot, input count, output ready);
endinterface

interface nrrp_rsp_if;
   import nrrp_pkg::*;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic               valid_res;
   modport source (output valid, output index, output valid_res, input ready);
   modport sink (input valid, input index, input valid_res, output ready);
endinterface

interface nrrp_csr_if;
   import nrrp_pkg::*;
   logic             valid;
   logic             ready;
   logic [RNG_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/nrrp_divider.sv -----
`default_nettype none

module nrrp_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire nrrp_pkg::div_req_type div_req,
   output nrrp_pkg::div_rsp_type      div_rsp
);
   import nrrp_pkg::*;

   logic [DIV_W-1:0]   num_ff, num_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] den_ff, den_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W:0]   diff;

   assign trial = {rem_ff, num_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         num_in  = div_req.dividend;
         den_in  = div_req.divisor;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in  = num_ff << 1;
         rem_in  = (trial >= {1'b0, den_ff}) ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < den_ff)
      else $error("remainder not below divisor");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done without a running division");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/no_repeat_random_pick_unit.sv -----
// Random pool index picker that avoids repeating the previous pick of slots 0 to 2.
// req channel: slot and count; accepted when valid and ready are high.
//   ready is high only while the unit is idle; one request is worked at a time.
// rsp channel: index and valid_res, one transaction per request, held in an
//   output register until taken. A new request is accepted while a finished
//   result still waits; the next result waits in the sequencer until the
//   output register frees.
// csr channel: seed write, always ready; reloads the xorshift32 state
//   (zero loads the default seed). Write only while the unit is idle.
// Steps from request acceptance to rsp valid:
//   count 0 or 1: no draw.
//   otherwise: one draw, and a second draw when a tracked slot's pick matches
//   its last pick. Each draw runs a bit-serial 32-by-8 modulo on the one
//   shared divider.
// Reset (synchronous) loads the default seed, clears all slot histories to
//   "no pick" and empties the output register.
`default_nettype none

module no_repeat_random_pick_unit (
   input wire logic   clock,
   input wire logic   reset,
   nrrp_req_if.sink   req_chan,
   nrrp_rsp_if.source rsp_chan,
   nrrp_csr_if.sink   csr_chan
);
   import nrrp_pkg::*;

   state_type          state_ff, state_in;
   logic [RNG_W-1:0]   rng_ff, rng_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic               vres_ff, vres_in;
   logic [INDEX_W-1:0] last_ff [SLOTS];
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic               rsp_vres_ff, rsp_vres_in;
   logic               rsp_valid_ff, rsp_valid_in;

   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic               req_take;
   logic               csr_take;
   logic               out_free;
   logic               tracked;
   logic [INDEX_W-1:0] hist_sel;
   logic               hist_we;
   logic [INDEX_W-1:0] hist_wdata;
   logic [COUNT_W:0]   sum;
   logic [COUNT_W:0]   sum_wrap;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_take       = csr_chan.valid && csr_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign tracked = (32'(slot_ff) < SLOTS);

   always_comb begin
      hist_sel = NO_PICK;
      for (int i = 0; i < SLOTS; i++) begin
         if (32'(slot_ff) == i) begin
            hist_sel = last_ff[i];
         end
      end
   end

   assign sum      = {1'b0, idx_ff} + 1'b1 + {1'b0, div_rsp.remainder};
   assign sum_wrap = sum - {1'b0, count_ff};

   nrrp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_chan.count <= COUNT_W'(1)) ? ST_FIN : ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               state_in = (tracked && hist_sel == div_rsp.remainder) ? ST_DIV2 : ST_FIN;
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      rng_in           = rng_ff;
      slot_in          = slot_ff;
      count_in         = count_ff;
      idx_in           = idx_ff;
      vres_in          = vres_ff;
      rsp_index_in     = rsp_index_ff;
      rsp_vres_in      = rsp_vres_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      hist_we          = 1'b0;
      hist_wdata       = div_rsp.remainder;
      div_req.start    = 1'b0;
      div_req.dividend = xorshift(rng_ff);
      div_req.divisor  = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               slot_in  = req_chan.slot;
               count_in = req_chan.count;
               idx_in   = '0;
               vres_in  = (req_chan.count != '0);
               if (req_chan.count > COUNT_W'(1)) begin
                  rng_in          = xorshift(rng_ff);
                  div_req.start   = 1'b1;
                  div_req.divisor = req_chan.count;
               end
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               idx_in = div_rsp.remainder;
               if (tracked && hist_sel == div_rsp.remainder) begin
                  rng_in          = xorshift(rng_ff);
                  div_req.start   = 1'b1;
                  div_req.divisor = count_ff - 1'b1;
               end else begin
                  hist_we = tracked;
               end
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               idx_in     = (sum >= {1'b0, count_ff}) ? sum_wrap[INDEX_W-1:0]
                                                      : sum[INDEX_W-1:0];
               hist_wdata = idx_in;
               hist_we    = tracked;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_ff;
               rsp_vres_in  = vres_ff;
            end
         end
         default: ;
      endcase
      if (csr_take) begin
         rng_in = (csr_chan.data != '0) ? csr_chan.data : DEFAULT_SEED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rng_ff       <= DEFAULT_SEED;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            last_ff[i] <= NO_PICK;
         end
      end else begin
         state_ff     <= state_in;
         rng_ff       <= rng_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < SLOTS; i++) begin
            if (hist_we && 32'(slot_ff) == i) begin
               last_ff[i] <= hist_wdata;
            end
         end
      end
      slot_ff      <= slot_in;
      count_ff     <= count_in;
      idx_ff       <= idx_in;
      vres_ff      <= vres_in;
      rsp_index_ff <= rsp_index_in;
      rsp_vres_ff  <= rsp_vres_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.index     = rsp_index_ff;
   assign rsp_chan.valid_res = rsp_vres_ff;

`ifndef NO_ASSERTIONS
   a_fin_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && vres_ff) |-> idx_ff < count_ff)
      else $error("picked index not below count");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && !vres_ff) |-> (idx_ff == '0 && count_ff == '0))
      else $error("empty pool result malformed");
   a_redraw_differs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV2 && div_rsp.done) |=> idx_ff != $past(idx_ff))
      else $error("second draw repeated the last pick");
   a_div_done_busy: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV1 || state_ff == ST_DIV2))
      else $error("divider result outside a draw");
`endif

endmodule

`default_nettype wire
